/* hw/rtl/lphm_pkg.sv */
// shared types and constants for the linear probe hash map
`timescale 1ns / 1ps

package lphm_pkg;

  // width of the population counter and load limit
  localparam int unsigned CntW = 10;
  localparam int unsigned KeyW = 32;
  localparam int unsigned DataW = 32;
  localparam int unsigned StatusW = 3;

  // load limit after reset
  localparam logic [CntW-1:0] MaxEntriesReset = 10'd819;

  // avalanche mixer constants
  localparam logic [31:0] MixMulA = 32'h85eb_ca6b;
  localparam logic [31:0] MixMulB = 32'hc2b2_ae35;
  localparam int unsigned MixShiftA = 16;
  localparam int unsigned MixShiftB = 13;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    STAT_FOUND     = 3'd0,
    STAT_NOT_FOUND = 3'd1,
    STAT_INSERTED  = 3'd2,
    STAT_PRESENT   = 3'd3,
    STAT_FULL      = 3'd4
  } status_e;

  // request modes
  typedef enum logic {
    MODE_FIND   = 1'b0,
    MODE_INSERT = 1'b1
  } mode_e;

  // hash unit sequencer
  typedef enum logic [2:0] {
    MIX_IDLE,
    MIX_MUL1,
    MIX_MUL2,
    MIX_FOLD,
    MIX_QUOT,
    MIX_REM,
    MIX_MOD,
    MIX_OUT
  } mix_state_e;

  // top level sequencer
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_DONE
  } ctl_state_e;

endpackage

/* hw/rtl/linear_probe_hash_map.sv */
// top level: open addressing hash map with linear probing
`timescale 1ns / 1ps

// Requests enter on the input channel (mode, key, value_in) and each gives
// one result (status, value_out, entry_count) on the output channel. Both
// channels move a transaction when valid is high and stall is low.
// The max_entries load limit is written over the config channel, which is
// always ready; write it only while no request is in flight.
// After reset the key memory is swept to empty, one slot per cycle, over
// all CAPACITY slots; in_stall_o stays high during the sweep.
// One request at a time: the next request is accepted only after the result
// of the last one has been moved into the output register. Probing reads
// one key memory slot per cycle. The hash uses one shared multiplier for
// both mixing rounds; when CAPACITY is not a power of two the slot
// reduction adds a reciprocal multiply, a multiply back and one correction
// on the same multiplier. A key of zero skips hashing and probing and goes
// straight to the done state.
// The result sits in an output register; if the receiver stalls, the next
// request is still accepted and processed, and waits for the register.
// value_out is zero unless the status is found or already present.
module linear_probe_hash_map #(
  parameter int unsigned CAPACITY   = 1024,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             mode_i,
  input  logic [lphm_pkg::KeyW-1:0]        key_i,
  input  logic [lphm_pkg::DataW-1:0]       value_in_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [lphm_pkg::StatusW-1:0]     status_o,
  output logic [lphm_pkg::DataW-1:0]       value_out_o,
  output logic [lphm_pkg::CntW-1:0]        entry_count_o,
  // config channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lphm_pkg::CntW-1:0]        cfg_data_i
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam logic [AW-1:0] LastSlot = AW'(CAPACITY - 1);

  lphm_pkg::ctl_state_e state_q, state_d;

  // key and value memories
  logic [lphm_pkg::KeyW-1:0] key_mem [CAPACITY];
  logic [VALUE_BITS-1:0]     val_mem [CAPACITY];

  logic [AW-1:0]                  clr_q;
  logic [AW-1:0]                  slot_q, slot_d;
  logic [AW-1:0]                  probe_q, probe_d;
  logic [lphm_pkg::CntW-1:0]      pop_q, pop_d;
  logic [lphm_pkg::CntW-1:0]      max_q;
  logic                           mode_q;
  logic [lphm_pkg::KeyW-1:0]      key_q;
  logic [lphm_pkg::DataW-1:0]     vin_q;
  lphm_pkg::status_e              res_status_q, res_status_d;
  logic [lphm_pkg::DataW-1:0]     res_value_q, res_value_d;

  logic                           out_valid_q;
  lphm_pkg::status_e              out_status_q;
  logic [lphm_pkg::DataW-1:0]     out_value_q;
  logic [lphm_pkg::CntW-1:0]      out_count_q;

  logic [lphm_pkg::KeyW-1:0]      rd_key_q;
  logic [VALUE_BITS-1:0]          rd_val_q;
  logic [AW-1:0]                  rd_addr;

  logic                           key_we;
  logic                           val_we;
  logic [AW-1:0]                  wr_addr;
  logic [lphm_pkg::KeyW-1:0]      wr_key;
  logic [VALUE_BITS-1:0]          wr_val;
  logic [63:0]                    vin_wide;
  logic [63:0]                    rd_val_wide;

  logic                           in_take;
  logic                           out_free;
  logic                           mix_start;
  logic                           mix_done;
  logic [AW-1:0]                  mix_slot;
  logic [AW-1:0]                  slot_next;
  logic                           is_insert;

  // hash unit
  lphm_mixer #(
    .CAPACITY(CAPACITY)
  ) u_mixer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mix_start),
    .key_i  (key_q),
    .done_o (mix_done),
    .slot_o (mix_slot)
  );

  assign in_stall_o = (state_q != lphm_pkg::ST_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign is_insert  = (mode_q == lphm_pkg::MODE_INSERT);
  assign slot_next  = (slot_q == LastSlot) ? '0 : slot_q + AW'(1);
  assign mix_start  = (state_q == lphm_pkg::ST_HASH) && !mix_done;

  // value width conversion
  assign vin_wide    = 64'(vin_q);
  assign wr_val      = vin_wide[VALUE_BITS-1:0];
  assign rd_val_wide = 64'(rd_val_q);

  // sequencer: next state, probe decisions and memory controls
  always_comb begin
    state_d      = state_q;
    slot_d       = slot_q;
    probe_d      = probe_q;
    pop_d        = pop_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    rd_addr      = slot_q;
    key_we       = 1'b0;
    val_we       = 1'b0;
    wr_addr      = slot_q;
    wr_key       = key_q;
    case (state_q)
      lphm_pkg::ST_CLEAR: begin
        key_we  = 1'b1;
        wr_addr = clr_q;
        wr_key  = '0;
        if (clr_q == LastSlot) state_d = lphm_pkg::ST_IDLE;
      end
      lphm_pkg::ST_IDLE: begin
        if (in_take) begin
          if (key_i == '0) begin
            res_status_d = lphm_pkg::STAT_FULL;
            res_value_d  = '0;
            state_d      = lphm_pkg::ST_DONE;
          end else begin
            state_d = lphm_pkg::ST_HASH;
          end
        end
      end
      lphm_pkg::ST_HASH: begin
        if (mix_done) begin
          rd_addr = mix_slot;
          slot_d  = mix_slot;
          probe_d = '0;
          state_d = lphm_pkg::ST_PROBE;
        end
      end
      lphm_pkg::ST_PROBE: begin
        res_value_d = '0;
        if (rd_key_q == '0) begin
          // empty slot ends the chain
          state_d = lphm_pkg::ST_DONE;
          if (!is_insert) begin
            res_status_d = lphm_pkg::STAT_NOT_FOUND;
          end else if (pop_q < max_q) begin
            key_we       = 1'b1;
            val_we       = 1'b1;
            pop_d        = pop_q + lphm_pkg::CntW'(1);
            res_status_d = lphm_pkg::STAT_INSERTED;
          end else begin
            res_status_d = lphm_pkg::STAT_FULL;
          end
        end else if (rd_key_q == key_q) begin
          // key already stored
          state_d      = lphm_pkg::ST_DONE;
          res_value_d  = rd_val_wide[lphm_pkg::DataW-1:0];
          res_status_d = is_insert ? lphm_pkg::STAT_PRESENT : lphm_pkg::STAT_FOUND;
        end else if (probe_q == LastSlot) begin
          // every slot visited
          state_d      = lphm_pkg::ST_DONE;
          res_status_d = is_insert ? lphm_pkg::STAT_FULL : lphm_pkg::STAT_NOT_FOUND;
        end else begin
          rd_addr = slot_next;
          slot_d  = slot_next;
          probe_d = probe_q + AW'(1);
        end
      end
      lphm_pkg::ST_DONE: begin
        if (out_free) state_d = lphm_pkg::ST_IDLE;
      end
      default: state_d = lphm_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lphm_pkg::ST_CLEAR;
      clr_q       <= '0;
      pop_q       <= '0;
      max_q       <= lphm_pkg::MaxEntriesReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pop_q   <= pop_d;
      if (state_q == lphm_pkg::ST_CLEAR) clr_q <= clr_q + AW'(1);
      if (cfg_valid_i && cfg_ready_o) max_q <= cfg_data_i;
      if (state_q == lphm_pkg::ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request and result payload registers
  always_ff @(posedge clk_i) begin
    slot_q       <= slot_d;
    probe_q      <= probe_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    if (in_take) begin
      mode_q <= mode_i;
      key_q  <= key_i;
      vin_q  <= value_in_i;
    end
    if (state_q == lphm_pkg::ST_DONE && out_free) begin
      out_status_q <= res_status_q;
      out_value_q  <= res_value_q;
      out_count_q  <= pop_q;
    end
  end

  // memory ports: one write, one registered read each
  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[wr_addr] <= wr_key;
    if (val_we) val_mem[wr_addr] <= wr_val;
    rd_key_q <= key_mem[rd_addr];
    rd_val_q <= val_mem[rd_addr];
  end

  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign value_out_o   = out_value_q;
  assign entry_count_o = out_count_q;

endmodule

/* hw/rtl/lphm_mixer.sv */
// hash unit: shared multiplier avalanche mixer and reciprocal slot reduction
`timescale 1ns / 1ps

module lphm_mixer #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [lphm_pkg::KeyW-1:0]    key_i,
  output logic                         done_o,
  output logic [$clog2(CAPACITY)-1:0]  slot_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam bit CapPow2 = ((CAPACITY & (CAPACITY - 1)) == 0);
  localparam logic [AW:0] CapExt = (AW + 1)'(CAPACITY);
  // capacity and its scaled reciprocal floor(2^32 / CAPACITY)
  localparam logic [31:0] CapWord  = 32'(CAPACITY);
  localparam logic [31:0] CapRecip = 32'((64'd1 << 32) / 64'(CAPACITY));

  lphm_pkg::mix_state_e state_q, state_d;

  logic [31:0]   h_q;
  logic [31:0]   sh_q;
  logic [AW:0]   rem_q;
  logic [AW-1:0] slot_q;

  logic [31:0]   mul_a;
  logic [31:0]   mul_b;
  logic [63:0]   prod;
  logic [31:0]   h_fold;
  logic [31:0]   rem_diff;
  logic [AW:0]   rem_fix;

  // one multiplier shared by both mixing rounds and the slot reduction
  always_comb begin
    mul_a = h_q;
    mul_b = lphm_pkg::MixMulA;
    case (state_q)
      lphm_pkg::MIX_MUL2: begin
        mul_a = h_q ^ (h_q >> lphm_pkg::MixShiftB);
        mul_b = lphm_pkg::MixMulB;
      end
      lphm_pkg::MIX_QUOT: begin
        mul_a = sh_q;
        mul_b = CapRecip;
      end
      lphm_pkg::MIX_REM: begin
        mul_a = h_q;
        mul_b = CapWord;
      end
      default: begin
      end
    endcase
    prod = mul_a * mul_b;
  end

  assign h_fold = h_q ^ (h_q >> lphm_pkg::MixShiftA);

  // quotient estimate is low by at most one, so the remainder is below 2 * CAPACITY
  assign rem_diff = sh_q - prod[31:0];
  assign rem_fix  = (rem_q >= CapExt) ? rem_q - CapExt : rem_q;

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lphm_pkg::MIX_IDLE: begin
        if (start_i) state_d = lphm_pkg::MIX_MUL1;
      end
      lphm_pkg::MIX_MUL1: state_d = lphm_pkg::MIX_MUL2;
      lphm_pkg::MIX_MUL2: state_d = lphm_pkg::MIX_FOLD;
      lphm_pkg::MIX_FOLD: begin
        state_d = CapPow2 ? lphm_pkg::MIX_OUT : lphm_pkg::MIX_QUOT;
      end
      lphm_pkg::MIX_QUOT: state_d = lphm_pkg::MIX_REM;
      lphm_pkg::MIX_REM:  state_d = lphm_pkg::MIX_MOD;
      lphm_pkg::MIX_MOD:  state_d = lphm_pkg::MIX_OUT;
      lphm_pkg::MIX_OUT:  state_d = lphm_pkg::MIX_IDLE;
      default: state_d = lphm_pkg::MIX_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lphm_pkg::MIX_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      lphm_pkg::MIX_IDLE: begin
        h_q <= key_i ^ (key_i >> lphm_pkg::MixShiftA);
      end
      lphm_pkg::MIX_MUL1, lphm_pkg::MIX_MUL2: begin
        h_q <= prod[31:0];
      end
      lphm_pkg::MIX_FOLD: begin
        sh_q   <= h_fold;
        slot_q <= CapPow2 ? h_fold[AW-1:0] : '0;
      end
      lphm_pkg::MIX_QUOT: begin
        h_q <= prod[63:32];
      end
      lphm_pkg::MIX_REM: begin
        rem_q <= rem_diff[AW:0];
      end
      lphm_pkg::MIX_MOD: begin
        slot_q <= rem_fix[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  assign done_o = (state_q == lphm_pkg::MIX_OUT);
  assign slot_o = slot_q;

endmodule

/* tb/tb_linear_probe_hash_map.sv */
// self-checking testbench for the linear probe hash map
`timescale 1ns / 1ps

// tracks table contents and the queue of expected responses
class hash_map_scoreboard #(int unsigned Slots = 1024);
  typedef struct {
    lphm_pkg::status_e               status;
    logic [lphm_pkg::DataW-1:0]      value;
    logic [lphm_pkg::CntW-1:0]       count;
  } outcome_t;

  logic [lphm_pkg::KeyW-1:0]  slot_key [Slots];
  logic [lphm_pkg::DataW-1:0] slot_val [Slots];
  logic [lphm_pkg::CntW-1:0]  population;
  logic [lphm_pkg::CntW-1:0]  limit;
  outcome_t                   expected_q [$];
  int unsigned                errors;

  function new();
    for (int i = 0; i < Slots; i++) begin
      slot_key[i] = '0;
      slot_val[i] = '0;
    end
    population = '0;
    limit      = lphm_pkg::MaxEntriesReset;
    errors     = 0;
  endfunction

  // fmix32 avalanche mixer
  function logic [31:0] mix(input logic [31:0] k);
    logic [31:0] h;
    h = k;
    h = h ^ (h >> lphm_pkg::MixShiftA);
    h = h * lphm_pkg::MixMulA;
    h = h ^ (h >> lphm_pkg::MixShiftB);
    h = h * lphm_pkg::MixMulB;
    h = h ^ (h >> lphm_pkg::MixShiftA);
    return h;
  endfunction

  function int unsigned home_slot(input logic [lphm_pkg::KeyW-1:0] k);
    return mix(k) % Slots;
  endfunction

  function void set_limit(input logic [lphm_pkg::CntW-1:0] v);
    limit = v;
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  // walk the probe chain for one accepted transaction and queue its response
  function void note_request(input lphm_pkg::mode_e m, input logic [lphm_pkg::KeyW-1:0] k,
                             input logic [lphm_pkg::DataW-1:0] v);
    outcome_t    o;
    int unsigned slot;
    o.status = lphm_pkg::STAT_FULL;
    o.value  = '0;
    if (k != '0) begin
      slot = home_slot(k);
      if (m == lphm_pkg::MODE_FIND) o.status = lphm_pkg::STAT_NOT_FOUND;
      for (int n = 0; n < Slots; n++) begin
        // empty slot ends the chain
        if (slot_key[slot] == '0) begin
          if (m == lphm_pkg::MODE_FIND) begin
            o.status = lphm_pkg::STAT_NOT_FOUND;
          end else if (population < limit) begin
            slot_key[slot] = k;
            slot_val[slot] = v;
            population     = population + 1'b1;
            o.status       = lphm_pkg::STAT_INSERTED;
          end else begin
            o.status = lphm_pkg::STAT_FULL;
          end
          break;
        end
        // key hit
        if (slot_key[slot] == k) begin
          if (m == lphm_pkg::MODE_INSERT) o.status = lphm_pkg::STAT_PRESENT;
          else o.status = lphm_pkg::STAT_FOUND;
          o.value = slot_val[slot];
          break;
        end
        slot = (slot + 1) % Slots;
      end
    end
    o.count = population;
    expected_q.push_back(o);
  endfunction

  // compare one response against the oldest expectation
  function void check_result(input logic [lphm_pkg::StatusW-1:0] st,
                             input logic [lphm_pkg::DataW-1:0] val,
                             input logic [lphm_pkg::CntW-1:0] cnt);
    outcome_t o;
    if (expected_q.size() == 0) begin
      $error("response with no request pending: status %0d value %0h count %0d",
             st, val, cnt);
      errors++;
    end else begin
      o = expected_q.pop_front();
      if (st !== o.status) begin
        $error("status: expected %0d, got %0d", o.status, st);
        errors++;
      end
      if (val !== o.value) begin
        $error("value_out: expected %0h, got %0h", o.value, val);
        errors++;
      end
      if (cnt !== o.count) begin
        $error("entry_count: expected %0d, got %0d", o.count, cnt);
        errors++;
      end
    end
  endfunction
endclass

module tb_linear_probe_hash_map;

  localparam int unsigned Capacity   = 1024;
  localparam int unsigned CycleLimit = 8_000_000;
  localparam logic [lphm_pkg::CntW-1:0] LimitTop = '1;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY
  } stall_kind_e;

  logic                            clk         = 1'b0;
  logic                            rst_n       = 1'b0;
  logic                            in_valid    = 1'b0;
  logic                            in_stall;
  logic                            mode        = 1'b0;
  logic [lphm_pkg::KeyW-1:0]       key         = '0;
  logic [lphm_pkg::DataW-1:0]      value_in    = '0;
  logic                            out_valid;
  logic                            out_stall   = 1'b0;
  logic [lphm_pkg::StatusW-1:0]    status;
  logic [lphm_pkg::DataW-1:0]      value_out;
  logic [lphm_pkg::CntW-1:0]       entry_count;
  logic                            cfg_valid   = 1'b0;
  logic                            cfg_ready;
  logic [lphm_pkg::CntW-1:0]       cfg_data    = '0;

  hash_map_scoreboard #(Capacity) sb;
  logic [lphm_pkg::KeyW-1:0]       stored_keys [$];
  int unsigned                     burst_left  = 0;
  int unsigned                     cycles      = 0;
  stall_kind_e                     stall_kind  = STALL_NONE;
  int unsigned                     stall_left  = 0;

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  linear_probe_hash_map #(
    .CAPACITY  (Capacity),
    .VALUE_BITS(lphm_pkg::DataW)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .mode_i       (mode),
    .key_i        (key),
    .value_in_i   (value_in),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .status_o     (status),
    .value_out_o  (value_out),
    .entry_count_o(entry_count),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_data_i   (cfg_data)
  );

  // receiver backpressure: switches between free, light and heavy stall
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_kind <= stall_kind_e'($urandom_range(0, 2));
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_kind)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      default:     out_stall <= ($urandom_range(0, 4) != 0);
    endcase
  end

  // response monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(status, value_out, entry_count);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb_linear_probe_hash_map: done, errors");
      $finish;
    end
  end

  // sender bursts and gaps
  task automatic pace();
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(40, 120);
      else burst_left = $urandom_range(0, 12);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // one request transaction
  task automatic send(input lphm_pkg::mode_e m, input logic [lphm_pkg::KeyW-1:0] k,
                      input logic [lphm_pkg::DataW-1:0] v);
    in_valid <= 1'b1;
    mode     <= m;
    key      <= k;
    value_in <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(m, k, v);
    pace();
  endtask

  // hold off until every response is back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_limit(input logic [lphm_pkg::CntW-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_limit(v);
  endtask

  function automatic logic [lphm_pkg::KeyW-1:0] nonzero_key();
    logic [lphm_pkg::KeyW-1:0] k;
    k = $urandom();
    if (k == '0) k = 32'h0000_0001;
    return k;
  endfunction

  // first nonzero key at or above a start value that hashes to a given slot
  function automatic logic [lphm_pkg::KeyW-1:0] key_for_slot(
      input int unsigned target, input logic [lphm_pkg::KeyW-1:0] from);
    logic [lphm_pkg::KeyW-1:0] k;
    k = from;
    while (k == '0 || sb.home_slot(k) != target) k++;
    return k;
  endfunction

  task automatic insert_fresh();
    logic [lphm_pkg::KeyW-1:0] k;
    k = nonzero_key();
    stored_keys.push_back(k);
    send(lphm_pkg::MODE_INSERT, k, $urandom());
  endtask

  // mostly well-formed traffic over known and fresh keys, some noise
  task automatic random_request();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 3)
      send(lphm_pkg::mode_e'($urandom_range(0, 1)), '0, $urandom());
    else if (pick < 40 && stored_keys.size() != 0)
      send(lphm_pkg::MODE_FIND, stored_keys[$urandom_range(0, stored_keys.size() - 1)],
           $urandom());
    else if (pick < 55)
      send(lphm_pkg::MODE_FIND, nonzero_key(), $urandom());
    else if (pick < 85)
      insert_fresh();
    else if (pick < 95 && stored_keys.size() != 0)
      send(lphm_pkg::MODE_INSERT, stored_keys[$urandom_range(0, stored_keys.size() - 1)],
           $urandom());
    else
      send(lphm_pkg::mode_e'($urandom_range(0, 1)), $urandom(), $urandom());
  endtask

  initial begin
    logic [lphm_pkg::KeyW-1:0] wrap_a, wrap_b, wrap_c, wrap_miss;
    logic [lphm_pkg::CntW-1:0] mid_limit;
    sb = new();
    // keys that collide at the last slot and wrap to slot zero
    wrap_a    = key_for_slot(Capacity - 1, 32'h0001_0000);
    wrap_b    = key_for_slot(Capacity - 1, wrap_a + 1);
    wrap_miss = key_for_slot(Capacity - 1, wrap_b + 1);
    wrap_c    = key_for_slot(0, 32'h0002_0000);

    // reset, then wait out the clearing sweep
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);

    // limit of one entry
    write_limit(10'd1);
    send(lphm_pkg::MODE_INSERT, 32'hDEAD_BEEF, 32'hFFFF_FFFF);
    send(lphm_pkg::MODE_INSERT, 32'h8000_0000, 32'h1111_1111);
    send(lphm_pkg::MODE_FIND,   32'h8000_0000, 32'h0);
    send(lphm_pkg::MODE_INSERT, 32'hDEAD_BEEF, 32'h0);
    drain();

    // limit of zero: new keys always full, present keys still answer
    write_limit(10'd0);
    send(lphm_pkg::MODE_INSERT, 32'h7FFF_FFFF, 32'h2222_2222);
    send(lphm_pkg::MODE_INSERT, 32'hDEAD_BEEF, 32'h3333_3333);
    send(lphm_pkg::MODE_FIND,   32'hDEAD_BEEF, 32'h0);
    drain();

    // default limit: zero key, extreme keys, collisions and wraparound
    write_limit(lphm_pkg::MaxEntriesReset);
    send(lphm_pkg::MODE_FIND,   '0, 32'h0);
    send(lphm_pkg::MODE_INSERT, '0, 32'hFFFF_FFFF);
    send(lphm_pkg::MODE_INSERT, 32'hFFFF_FFFF, 32'h0);
    send(lphm_pkg::MODE_FIND,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(lphm_pkg::MODE_INSERT, wrap_a, 32'hA5A5_5A5A);
    send(lphm_pkg::MODE_INSERT, wrap_b, 32'h5A5A_A5A5);
    send(lphm_pkg::MODE_INSERT, wrap_c, 32'hC3C3_3C3C);
    send(lphm_pkg::MODE_FIND,   wrap_c, 32'h0);
    send(lphm_pkg::MODE_FIND,   wrap_b, 32'h0);
    send(lphm_pkg::MODE_FIND,   wrap_miss, 32'h0);
    send(lphm_pkg::MODE_INSERT, wrap_b, 32'h0);
    send(lphm_pkg::MODE_INSERT, 32'h0000_0001, 32'h0000_0001);
    send(lphm_pkg::MODE_FIND,   32'h0000_0001, 32'h0);
    send(lphm_pkg::MODE_INSERT, 32'h8000_0000, 32'h1111_1111);

    // random traffic at the default limit, with occasional full drains
    repeat (120) begin
      random_request();
      if ($urandom_range(0, 99) == 0) drain();
    end
    drain();

    // limit a little above the current population so it is reached
    mid_limit = sb.population + lphm_pkg::CntW'($urandom_range(10, 25));
    write_limit(mid_limit);
    repeat (80) random_request();
    drain();

    // highest limit: fill the table up to the limit, then work on a nearly full table
    write_limit(LimitTop);
    while (sb.population < LimitTop) insert_fresh();
    repeat (60) random_request();
    drain();

    if (sb.errors == 0) begin
      $display("tb_linear_probe_hash_map: done, clean");
    end else begin
      $display("tb_linear_probe_hash_map: done, errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/lphm_pkg.sv
hw/rtl/lphm_mixer.sv
hw/rtl/linear_probe_hash_map.sv
tb/tb_linear_probe_hash_map.sv
